FILE: rtl/mmrc_pkg.sv
`timescale 1ns / 1ps
// Package for the memory map region coalescer: field widths, region classes,
// the UEFI type decoder and the item structs passed between the blocks.
// Depends on nothing.

package mmrc_pkg;

   // Fixed field widths.
   localparam int DESC_TYPE_W = 32;
   localparam int PHYS_W      = 52;
   localparam int PAGES_W     = 40;
   localparam int SIZE_W      = 53;
   localparam int SLOT_OUT_W  = 8;
   localparam int COUNT_W     = 9;
   localparam int PAGE_SHIFT  = 12;

   // Depth of the result queue in front of the output channel.
   localparam int RSP_DEPTH   = 4;

   // UEFI memory type numbers that map to a class other than reserved.
   localparam logic [DESC_TYPE_W-1:0] MT_LOADER_CODE    = 32'd1;
   localparam logic [DESC_TYPE_W-1:0] MT_LOADER_DATA    = 32'd2;
   localparam logic [DESC_TYPE_W-1:0] EFI_BS_CODE       = 32'd3;
   localparam logic [DESC_TYPE_W-1:0] EFI_BS_DATA       = 32'd4;
   localparam logic [DESC_TYPE_W-1:0] EFI_RT_CODE       = 32'd5;
   localparam logic [DESC_TYPE_W-1:0] EFI_RT_DATA       = 32'd6;
   localparam logic [DESC_TYPE_W-1:0] EFI_CONVENTIONAL  = 32'd7;
   localparam logic [DESC_TYPE_W-1:0] EFI_ACPI_RECLAIM  = 32'd9;
   localparam logic [DESC_TYPE_W-1:0] EFI_ACPI_NVS      = 32'd10;
   localparam logic [DESC_TYPE_W-1:0] EFI_MMIO          = 32'd11;
   localparam logic [DESC_TYPE_W-1:0] EFI_MMIO_PORT     = 32'd12;

   typedef enum logic [2:0] {
      CLS_RESERVED   = 3'd0,
      CLS_AVAILABLE  = 3'd1,
      CLS_BOOTLOADER = 3'd2,
      CLS_FIRMWARE   = 3'd3,
      CLS_ACPI       = 3'd4,
      CLS_MMIO       = 3'd5
   } region_class_type;

   // A classified descriptor as it waits between the front and the back.
   typedef struct packed {
      region_class_type     cls;
      logic                 usable;
      logic [PHYS_W-1:0]    start;
      logic [PAGES_W-1:0]   pages;
      logic                 last;
   } desc_item_type;

   // One result word.
   typedef struct packed {
      logic                  region_valid;
      logic [PHYS_W-1:0]     region_base;
      logic [SIZE_W-1:0]     region_size;
      region_class_type      region_class;
      logic [SLOT_OUT_W-1:0] region_slot;
      logic                  final_result;
      logic [PAGES_W-1:0]    usable_pages;
      logic [PAGES_W-1:0]    total_pages;
      logic [COUNT_W-1:0]    region_count;
      logic                  overflow;
   } rsp_item_type;

   // Map a UEFI memory type onto a region class; unknown types are reserved.
   function automatic region_class_type decode_class(input logic [DESC_TYPE_W-1:0] t);
      region_class_type c;
      unique case (t) inside
         MT_LOADER_DATA:                                       c = CLS_BOOTLOADER;
         MT_LOADER_CODE, EFI_BS_CODE, EFI_BS_DATA, EFI_CONVENTIONAL: c = CLS_AVAILABLE;
         EFI_RT_CODE, EFI_RT_DATA:                             c = CLS_FIRMWARE;
         EFI_ACPI_RECLAIM, EFI_ACPI_NVS:                       c = CLS_ACPI;
         EFI_MMIO, EFI_MMIO_PORT:                              c = CLS_MMIO;
         default:                                              c = CLS_RESERVED;
      endcase
      return c;
   endfunction

   // Saturating add of two page counts.
   function automatic logic [PAGES_W-1:0] sat_pages(input logic [PAGES_W-1:0] a,
                                                    input logic [PAGES_W-1:0] b);
      logic [PAGES_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[PAGES_W] ? {PAGES_W{1'b1}} : s[PAGES_W-1:0];
   endfunction

endpackage

FILE: rtl/mmrc_req_if.sv
`timescale 1ns / 1ps
// Descriptor channel: valid/ready handshake plus one memory descriptor.
// Depends on mmrc_pkg.

interface mmrc_req_if;
   import mmrc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [DESC_TYPE_W-1:0] desc_type;
   logic [PHYS_W-1:0]      phys_start;
   logic [PAGES_W-1:0]     page_count;
   logic                   is_last_desc;

   modport source (output valid, output desc_type, output phys_start,
                   output page_count, output is_last_desc, input ready);
   modport sink   (input valid, input desc_type, input phys_start,
                   input page_count, input is_last_desc, output ready);
endinterface

FILE: rtl/mmrc_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake plus one region or final report.
// Depends on mmrc_pkg.

interface mmrc_rsp_if;
   import mmrc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  region_valid;
   logic [PHYS_W-1:0]     region_base;
   logic [SIZE_W-1:0]     region_size;
   logic [2:0]            region_class;
   logic [SLOT_OUT_W-1:0] region_slot;
   logic                  final_result;
   logic [PAGES_W-1:0]    usable_pages;
   logic [PAGES_W-1:0]    total_pages;
   logic [COUNT_W-1:0]    region_count;
   logic                  overflow;

   modport source (output valid, output region_valid, output region_base,
                   output region_size, output region_class, output region_slot,
                   output final_result, output usable_pages, output total_pages,
                   output region_count, output overflow, input ready);
   modport sink   (input valid, input region_valid, input region_base,
                   input region_size, input region_class, input region_slot,
                   input final_result, input usable_pages, input total_pages,
                   input region_count, input overflow, output ready);
endinterface

FILE: rtl/mmrc_front.sv
`timescale 1ns / 1ps
// Front end: accepts descriptors, classifies them and holds them in a
// two-entry queue for the back end. Depends on mmrc_pkg and mmrc_req_if.

module mmrc_front #(
   parameter int ADDR_BITS = 52
) (
   input  logic                   clock,
   input  logic                   reset,
   mmrc_req_if.sink               req,
   output logic                   q_valid,
   input  logic                   q_ready,
   output mmrc_pkg::desc_item_type q_item
);
   import mmrc_pkg::*;

   localparam int FQ_DEPTH      = 2;
   localparam int FQ_PTR_W      = $clog2(FQ_DEPTH);
   localparam int FQ_CNT_W      = $clog2(FQ_DEPTH + 1);
   localparam int EFF_ADDR_BITS = (ADDR_BITS < PHYS_W) ? ADDR_BITS : PHYS_W;
   localparam logic [PHYS_W-1:0] ADDR_MASK =
      {PHYS_W{1'b1}} >> (PHYS_W - EFF_ADDR_BITS);

   desc_item_type        ent_ff [FQ_DEPTH];
   desc_item_type        item_in;
   logic [FQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FQ_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                 push;
   logic                 pop;

   // Classify the incoming descriptor.
   always_comb begin
      item_in.cls    = decode_class(req.desc_type);
      item_in.usable = (item_in.cls == CLS_AVAILABLE) || (item_in.cls == CLS_BOOTLOADER);
      item_in.start  = req.phys_start & ADDR_MASK;
      item_in.pages  = req.page_count;
      item_in.last   = req.is_last_desc;
   end

   // Queue handshakes.
   assign req.ready = (cnt_ff != FQ_CNT_W'(FQ_DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_valid && q_ready;
   assign q_item    = ent_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FQ_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + FQ_CNT_W'(push) - FQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

FILE: rtl/mmrc_back.sv
`timescale 1ns / 1ps
// Back end: keeps the open run, the page sums and the slot count, merges
// touching descriptors and produces up to two result words per descriptor.
// Depends on mmrc_pkg.

module mmrc_back #(
   parameter int MAX_REGIONS = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [mmrc_pkg::COUNT_W-1:0] csr_wr_data,
   input  logic                        q_valid,
   output logic                        q_ready,
   input  mmrc_pkg::desc_item_type     q_item,
   input  logic                        out_room,
   output logic [1:0]                  push_cnt,
   output mmrc_pkg::rsp_item_type      out0,
   output mmrc_pkg::rsp_item_type      out1
);
   import mmrc_pkg::*;

   localparam int SLOT_W0 = $clog2(MAX_REGIONS + 1);
   localparam int SLOT_W  = (SLOT_W0 > COUNT_W) ? SLOT_W0 : COUNT_W;
   localparam logic [SLOT_W-1:0] MAX_SLOTS = SLOT_W'(MAX_REGIONS);

   // Control state.
   logic [COUNT_W-1:0] first_slot_ff, first_slot_in;
   logic [SLOT_W-1:0]  slots_ff, slots_in;
   logic               run_valid_ff, run_valid_in;
   logic [PAGES_W-1:0] usable_ff, usable_in;
   logic [PAGES_W-1:0] unusable_ff, unusable_in;
   logic               stopped_ff, stopped_in;
   // Run payload, read only while run_valid_ff is set.
   logic [PHYS_W-1:0]  run_base_ff, run_base_in;
   logic [SIZE_W-1:0]  run_bytes_ff, run_bytes_in;
   region_class_type   run_class_ff, run_class_in;

   logic               take;
   logic               in_range;
   logic               process;
   logic               merge;
   logic [SIZE_W-1:0]  bytes;
   logic [SIZE_W:0]    run_end;
   logic [SIZE_W:0]    grown;
   logic               emit_a;
   logic               emit_f;
   logic               ovf_f;
   logic               stopped_mid;
   logic               run_valid_mid;
   logic [PHYS_W-1:0]  base_mid;
   logic [SIZE_W-1:0]  bytes_mid;
   region_class_type   class_mid;
   logic [SLOT_W-1:0]  slots_mid;
   logic [SLOT_W-1:0]  slots_fin;
   logic [PAGES_W-1:0] usable_mid;
   logic [PAGES_W-1:0] unusable_mid;
   rsp_item_type       res_a;
   rsp_item_type       res_f;

   assign q_ready = out_room;
   assign take    = q_valid && q_ready;

   // Range check, contiguity and the saturating run growth.
   always_comb begin
      bytes    = {1'b0, q_item.pages, {PAGE_SHIFT{1'b0}}};
      run_end  = {2'b00, run_base_ff} + {1'b0, run_bytes_ff};
      grown    = {1'b0, run_bytes_ff} + {1'b0, bytes};
      in_range = (slots_ff < MAX_SLOTS);
      process  = in_range && !stopped_ff;
      merge    = run_valid_ff && (run_class_ff == q_item.cls)
                 && (run_end == {2'b00, q_item.start});
   end

   // State after this descriptor, before any final flush.
   always_comb begin
      stopped_mid   = stopped_ff || !in_range;
      run_valid_mid = run_valid_ff;
      base_mid      = run_base_ff;
      bytes_mid     = run_bytes_ff;
      class_mid     = run_class_ff;
      slots_mid     = slots_ff;
      usable_mid    = usable_ff;
      unusable_mid  = unusable_ff;
      emit_a        = 1'b0;
      if (process) begin
         if (q_item.usable) begin
            usable_mid = sat_pages(usable_ff, q_item.pages);
         end else begin
            unusable_mid = sat_pages(unusable_ff, q_item.pages);
         end
         if (merge) begin
            bytes_mid = grown[SIZE_W] ? {SIZE_W{1'b1}} : grown[SIZE_W-1:0];
         end else begin
            emit_a        = run_valid_ff;
            slots_mid     = slots_ff + SLOT_W'(run_valid_ff);
            run_valid_mid = 1'b1;
            base_mid      = q_item.start;
            bytes_mid     = bytes;
            class_mid     = q_item.cls;
         end
      end
      emit_f    = run_valid_mid && (slots_mid < MAX_SLOTS);
      ovf_f     = stopped_mid || (run_valid_mid && !emit_f);
      slots_fin = slots_mid + SLOT_W'(emit_f);
   end

   // Result words: a region closed by this descriptor, and the final report.
   always_comb begin
      res_a.region_valid = 1'b1;
      res_a.region_base  = run_base_ff;
      res_a.region_size  = run_bytes_ff;
      res_a.region_class = run_class_ff;
      res_a.region_slot  = slots_ff[SLOT_OUT_W-1:0];
      res_a.final_result = 1'b0;
      res_a.usable_pages = usable_mid;
      res_a.total_pages  = sat_pages(usable_mid, unusable_mid);
      res_a.region_count = slots_mid[COUNT_W-1:0];
      res_a.overflow     = 1'b0;

      res_f.region_valid = emit_f;
      res_f.region_base  = emit_f ? base_mid : '0;
      res_f.region_size  = emit_f ? bytes_mid : '0;
      res_f.region_class = emit_f ? class_mid : CLS_RESERVED;
      res_f.region_slot  = emit_f ? slots_mid[SLOT_OUT_W-1:0] : '0;
      res_f.final_result = 1'b1;
      res_f.usable_pages = usable_mid;
      res_f.total_pages  = sat_pages(usable_mid, unusable_mid);
      res_f.region_count = slots_fin[COUNT_W-1:0];
      res_f.overflow     = ovf_f;

      out0     = emit_a ? res_a : res_f;
      out1     = res_f;
      push_cnt = take ? (2'(emit_a) + 2'(q_item.last)) : 2'd0;
   end

   // Next state: advance on a descriptor, restart the map after the last one; a CSR write reloads the slots.
   always_comb begin
      first_slot_in = first_slot_ff;
      slots_in      = slots_ff;
      run_valid_in  = run_valid_ff;
      usable_in     = usable_ff;
      unusable_in   = unusable_ff;
      stopped_in    = stopped_ff;
      run_base_in   = run_base_ff;
      run_bytes_in  = run_bytes_ff;
      run_class_in  = run_class_ff;
      if (take) begin
         run_base_in  = base_mid;
         run_bytes_in = bytes_mid;
         run_class_in = class_mid;
         if (q_item.last) begin
            slots_in     = SLOT_W'(first_slot_ff);
            run_valid_in = 1'b0;
            usable_in    = '0;
            unusable_in  = '0;
            stopped_in   = 1'b0;
         end else begin
            slots_in     = slots_mid;
            run_valid_in = run_valid_mid;
            usable_in    = usable_mid;
            unusable_in  = unusable_mid;
            stopped_in   = stopped_mid;
         end
      end
      if (csr_wr_en) begin
         first_slot_in = csr_wr_data;
         slots_in      = SLOT_W'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_slot_ff <= '0;
         slots_ff      <= '0;
         run_valid_ff  <= 1'b0;
         usable_ff     <= '0;
         unusable_ff   <= '0;
         stopped_ff    <= 1'b0;
      end else begin
         first_slot_ff <= first_slot_in;
         slots_ff      <= slots_in;
         run_valid_ff  <= run_valid_in;
         usable_ff     <= usable_in;
         unusable_ff   <= unusable_in;
         stopped_ff    <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      run_base_ff  <= run_base_in;
      run_bytes_ff <= run_bytes_in;
      run_class_ff <= run_class_in;
   end

`ifndef SYNTHESIS
   // The map state is back at its start once the last descriptor is taken.
   assert property (@(posedge clock) disable iff (reset)
      take && q_item.last && !csr_wr_en |=> !run_valid_ff && !stopped_ff
                                            && usable_ff == '0 && unusable_ff == '0)
      else $error("map state not restarted after last descriptor");

   // A region is only stored into a slot below the limit.
   assert property (@(posedge clock) disable iff (reset)
      take && emit_a |-> slots_ff < MAX_SLOTS)
      else $error("region stored beyond slot limit");
`endif

endmodule

FILE: rtl/mmrc_rsp_queue.sv
`timescale 1ns / 1ps
// Result queue: takes up to two result words per cycle from the back end
// and hands one word per cycle to the result channel while it is ready.
// Depends on mmrc_pkg and mmrc_rsp_if.

module mmrc_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             push_cnt,
   input  mmrc_pkg::rsp_item_type in0,
   input  mmrc_pkg::rsp_item_type in1,
   output logic                   out_room,
   mmrc_rsp_if.source             rsp
);
   import mmrc_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_item_type      mem_ff [RSP_DEPTH];
   rsp_item_type      head;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_nxt;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pop;

   // Room for two words regardless of what leaves this cycle.
   assign out_room   = (cnt_ff <= CNT_W'(RSP_DEPTH - 2));
   assign pop        = rsp.valid && rsp.ready;
   assign wr_ptr_nxt = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(push_cnt) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage: the first word lands at the write pointer, the second after it.
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= in0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_nxt] <= in1;
      end
   end

   // Drive the result channel from the head entry.
   assign head              = mem_ff[rd_ptr_ff];
   assign rsp.valid         = (cnt_ff != '0);
   assign rsp.region_valid  = head.region_valid;
   assign rsp.region_base   = head.region_base;
   assign rsp.region_size   = head.region_size;
   assign rsp.region_class  = head.region_class;
   assign rsp.region_slot   = head.region_slot;
   assign rsp.final_result  = head.final_result;
   assign rsp.usable_pages  = head.usable_pages;
   assign rsp.total_pages   = head.total_pages;
   assign rsp.region_count  = head.region_count;
   assign rsp.overflow      = head.overflow;

`ifndef SYNTHESIS
   // Words are pushed only when two entries are free.
   assert property (@(posedge clock) disable iff (reset)
      push_cnt != 2'd0 |-> cnt_ff <= CNT_W'(RSP_DEPTH - 2))
      else $error("result queue pushed without room");

   // The fill count follows pushes and pops exactly.
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> cnt_ff == $past(cnt_ff) + CNT_W'($past(push_cnt)) - CNT_W'($past(pop)))
      else $error("result queue count out of step");
`endif

endmodule

FILE: rtl/memory_map_region_coalescer.sv
`timescale 1ns / 1ps
// Top level of the memory map region coalescer: front end, back end and
// result queue. Depends on mmrc_pkg, mmrc_req_if, mmrc_rsp_if and submodules.
//
//   Channel   Direction  Handshake       Word
//   req_chan  in         valid / ready   one UEFI memory descriptor
//   rsp_chan  out        valid / ready   one merged region or final report
//   csr_*     in         write enable    first_region_slot
//
// One descriptor is taken per cycle while the result queue has room for two
// words; the back end updates the open run and writes its words into the
// result queue as it takes a descriptor. A last descriptor that closes a run
// yields two words, which the result queue drains at one word per cycle while
// the result channel is ready; only such descriptors then slow the rate.
// Reset is synchronous and clears all control state. Either side may stall:
// the two-entry descriptor queue and the four-entry result queue absorb it.

module memory_map_region_coalescer #(
   parameter int MAX_REGIONS = 256,
   parameter int ADDR_BITS   = 52
) (
   input  logic                         clock,
   input  logic                         reset,
   mmrc_req_if.sink                     req_chan,
   mmrc_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [mmrc_pkg::COUNT_W-1:0] csr_wr_data
);
   import mmrc_pkg::*;

   logic          q_valid;
   logic          q_ready;
   desc_item_type q_item;
   logic          out_room;
   logic [1:0]    push_cnt;
   rsp_item_type  out0;
   rsp_item_type  out1;

   mmrc_front #(
      .ADDR_BITS (ADDR_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_item  (q_item)
   );

   mmrc_back #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_item      (q_item),
      .out_room    (out_room),
      .push_cnt    (push_cnt),
      .out0        (out0),
      .out1        (out1)
   );

   mmrc_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push_cnt (push_cnt),
      .in0      (out0),
      .in1      (out1),
      .out_room (out_room),
      .rsp      (rsp_chan)
   );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for memory_map_region_coalescer: it drives descriptor maps,
// predicts every region and final report, and checks the words that come back.
// Depends on mmrc_pkg, mmrc_req_if, mmrc_rsp_if and the coalescer RTL.

module tb;
   import mmrc_pkg::*;

   localparam int MAX_SLOTS    = 256;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int SETTLE_WAIT  = 12;
   localparam int REPORT_LIMIT = 50;

   // Mirror of the coalescer: tracks the open run, the page sums and the slots,
   // and holds the words that the block still owes.
   class region_tracker;
      logic [COUNT_W-1:0] first_slot = '0;
      bit                 run_open;
      logic [PHYS_W-1:0]  run_base;
      logic [SIZE_W-1:0]  run_bytes;
      region_class_type   run_cls;
      logic [COUNT_W-1:0] slots_used;
      logic [PAGES_W-1:0] usable_sum;
      logic [PAGES_W-1:0] unusable_sum;
      bit                 halted;
      rsp_item_type       awaited_words[$];
      int                 errors;
      int                 regions_checked;
      int                 finals_checked;
      int                 overflows_checked;

      function new();
         restart();
      endfunction

      function void restart();
         run_open     = 0;
         run_base     = '0;
         run_bytes    = '0;
         run_cls      = CLS_RESERVED;
         slots_used   = first_slot;
         usable_sum   = '0;
         unusable_sum = '0;
         halted       = 0;
      endfunction

      // A register write also reloads the slot counter.
      function void set_first_slot(logic [COUNT_W-1:0] v);
         first_slot = v;
         slots_used = v;
      endfunction

      function int outstanding();
         return awaited_words.size();
      endfunction

      function logic [PAGES_W-1:0] add_clamped(logic [PAGES_W-1:0] a, logic [PAGES_W-1:0] b);
         logic [PAGES_W:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[PAGES_W] ? {PAGES_W{1'b1}} : s[PAGES_W-1:0];
      endfunction

      // UEFI type to region class; the loader, boot service and conventional types count as usable.
      function region_class_type classify(logic [DESC_TYPE_W-1:0] t, output bit usable);
         usable = 0;
         case (t)
            MT_LOADER_DATA: begin
               usable = 1;
               return CLS_BOOTLOADER;
            end
            MT_LOADER_CODE, EFI_BS_CODE, EFI_BS_DATA, EFI_CONVENTIONAL: begin
               usable = 1;
               return CLS_AVAILABLE;
            end
            EFI_RT_CODE, EFI_RT_DATA:      return CLS_FIRMWARE;
            EFI_ACPI_RECLAIM, EFI_ACPI_NVS: return CLS_ACPI;
            EFI_MMIO, EFI_MMIO_PORT:       return CLS_MMIO;
            default:                       return CLS_RESERVED;
         endcase
      endfunction

      function rsp_item_type make_word(bit valid, logic [PHYS_W-1:0] base,
                                       logic [SIZE_W-1:0] size, region_class_type cls,
                                       logic [SLOT_OUT_W-1:0] slot, bit fin, bit ovf);
         rsp_item_type w;
         w = '0;
         w.region_valid = valid;
         if (valid) begin
            w.region_base  = base;
            w.region_size  = size;
            w.region_class = cls;
            w.region_slot  = slot;
         end
         w.final_result = fin;
         w.usable_pages = usable_sum;
         w.total_pages  = add_clamped(usable_sum, unusable_sum);
         w.region_count = slots_used;
         w.overflow     = ovf;
         return w;
      endfunction

      // Work out the words that one accepted descriptor causes.
      function void take_descriptor(logic [DESC_TYPE_W-1:0] dtype, logic [PHYS_W-1:0] start,
                                    logic [PAGES_W-1:0] pages, bit last);
         region_class_type      cls;
         bit                    usable;
         logic [63:0]           bytes;
         logic [63:0]           run_end;
         logic [63:0]           merged;
         logic [SLOT_OUT_W-1:0] slot;
         bit                    emit;
         bit                    ovf;
         if (slots_used >= MAX_SLOTS) begin
            halted = 1;
         end else if (!halted) begin
            cls   = classify(dtype, usable);
            bytes = {24'b0, pages} << PAGE_SHIFT;
            if (usable) begin
               usable_sum = add_clamped(usable_sum, pages);
            end else begin
               unusable_sum = add_clamped(unusable_sum, pages);
            end
            run_end = {12'b0, run_base} + {11'b0, run_bytes};
            if (run_open && run_cls == cls && run_end == {12'b0, start}) begin
               merged    = {11'b0, run_bytes} + bytes;
               run_bytes = (merged > {11'b0, {SIZE_W{1'b1}}}) ? {SIZE_W{1'b1}}
                                                              : merged[SIZE_W-1:0];
            end else begin
               // A class change or a gap closes the open run into the next slot.
               if (run_open) begin
                  slot = slots_used[SLOT_OUT_W-1:0];
                  slots_used++;
                  awaited_words.push_back(make_word(1, run_base, run_bytes, run_cls,
                                                    slot, 0, 0));
               end
               run_open  = 1;
               run_base  = start;
               run_bytes = bytes[SIZE_W-1:0];
               run_cls   = cls;
            end
         end
         // The last descriptor flushes the run, if there is room, and reports totals.
         if (last) begin
            ovf  = halted;
            emit = 0;
            slot = '0;
            if (run_open) begin
               if (slots_used < MAX_SLOTS) begin
                  emit = 1;
                  slot = slots_used[SLOT_OUT_W-1:0];
                  slots_used++;
               end else begin
                  ovf = 1;
               end
            end
            awaited_words.push_back(make_word(emit, run_base, run_bytes, run_cls,
                                              slot, 1, ovf));
            restart();
         end
      endfunction

      function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
         if (want === got) return 1;
         if (errors < REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
         return 0;
      endfunction

      // Compare one returned word with the oldest one owed.
      function void check_word(rsp_item_type got);
         rsp_item_type want;
         bit           ok;
         if (awaited_words.size() == 0) begin
            if (errors < REPORT_LIMIT) begin
               $display("%0t: unexpected word, expected none, actual %0h", $time, got);
            end
            errors++;
            return;
         end
         want = awaited_words.pop_front();
         ok = 1;
         ok &= field_ok("region_valid", want.region_valid, got.region_valid);
         ok &= field_ok("region_base", want.region_base, got.region_base);
         ok &= field_ok("region_size", want.region_size, got.region_size);
         ok &= field_ok("region_class", want.region_class, got.region_class);
         ok &= field_ok("region_slot", want.region_slot, got.region_slot);
         ok &= field_ok("final_result", want.final_result, got.final_result);
         ok &= field_ok("usable_pages", want.usable_pages, got.usable_pages);
         ok &= field_ok("total_pages", want.total_pages, got.total_pages);
         ok &= field_ok("region_count", want.region_count, got.region_count);
         ok &= field_ok("overflow", want.overflow, got.overflow);
         if (!ok) errors++;
         if (want.region_valid) regions_checked++;
         if (want.final_result) finals_checked++;
         if (want.overflow) overflows_checked++;
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;
   bit                 hold_rsp = 0;
   int                 descs_sent = 0;
   int                 cycles = 0;
   region_tracker      tracker = new();

   mmrc_req_if req_bus ();
   mmrc_rsp_if rsp_bus ();

   memory_map_region_coalescer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words owed.", cycles,
                  tracker.outstanding());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Random idling, except in one long steady stretch of descriptors.
   function automatic bit take_break();
      if (descs_sent >= 600 && descs_sent < 800) return 0;
      return $urandom_range(99) < 22;
   endfunction

   // Result side: check at the rising edge, change ready at the falling edge.
   always begin
      rsp_item_type got;
      @(posedge clock);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.region_valid = rsp_bus.region_valid;
         got.region_base  = rsp_bus.region_base;
         got.region_size  = rsp_bus.region_size;
         got.region_class = region_class_type'(rsp_bus.region_class);
         got.region_slot  = rsp_bus.region_slot;
         got.final_result = rsp_bus.final_result;
         got.usable_pages = rsp_bus.usable_pages;
         got.total_pages  = rsp_bus.total_pages;
         got.region_count = rsp_bus.region_count;
         got.overflow     = rsp_bus.overflow;
         tracker.check_word(got);
      end
      @(negedge clock);
      rsp_bus.ready <= !hold_rsp && !take_break();
   end

   // Long hold-offs on the result side so the block backs up into its input.
   initial begin
      wait (descs_sent >= 420);
      hold_rsp = 1;
      repeat (90) @(posedge clock);
      hold_rsp = 0;
      wait (descs_sent >= 1050);
      hold_rsp = 1;
      repeat (90) @(posedge clock);
      hold_rsp = 0;
   end

   // Offer one descriptor; called and returning at a falling edge.
   // Each idle cycle is drawn on its own, so the input idles in about the same
   // share of cycles as the result side.
   task automatic offer_desc(input logic [DESC_TYPE_W-1:0] t, input logic [PHYS_W-1:0] s,
                             input logic [PAGES_W-1:0] p, input bit last);
      while (take_break()) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.desc_type    <= t;
      req_bus.phys_start   <= s;
      req_bus.page_count   <= p;
      req_bus.is_last_desc <= last;
      do @(posedge clock); while (!req_bus.ready);
      tracker.take_descriptor(t, s, p, last);
      descs_sent++;
      @(negedge clock);
   endtask

   function automatic logic [DESC_TYPE_W-1:0] pick_type();
      int r;
      r = $urandom_range(99);
      if (r < 70) begin
         case ($urandom_range(0, 10))
            0:       return MT_LOADER_CODE;
            1:       return MT_LOADER_DATA;
            2:       return EFI_BS_CODE;
            3:       return EFI_BS_DATA;
            4:       return EFI_RT_CODE;
            5:       return EFI_RT_DATA;
            6:       return EFI_CONVENTIONAL;
            7:       return EFI_ACPI_RECLAIM;
            8:       return EFI_ACPI_NVS;
            9:       return EFI_MMIO;
            default: return EFI_MMIO_PORT;
         endcase
      end
      if (r < 85) return DESC_TYPE_W'($urandom_range(0, 15));
      return $urandom();
   endfunction

   function automatic logic [PAGES_W-1:0] pick_pages();
      int r;
      r = $urandom_range(99);
      if (r < 60) return PAGES_W'($urandom_range(1, 256));
      if (r < 75) return PAGES_W'($urandom_range(0, 3));
      if (r < 92) return PAGES_W'($urandom_range(1, 1 << 20));
      if (r < 98) return PAGES_W'({$urandom(), $urandom()});
      return {PAGES_W{1'b1}};
   endfunction

   function automatic logic [PHYS_W-1:0] pick_addr();
      int r;
      r = $urandom_range(99);
      if (r < 50) return PHYS_W'({$urandom_range(0, 1 << 20), 12'b0});
      if (r < 80) return PHYS_W'({$urandom(), $urandom()});
      return {40'hFF_FFFF_FFFF - 40'($urandom_range(0, 64)), 12'h000};
   endfunction

   // A well-formed map: runs of touching descriptors with class changes and gaps.
   task automatic send_map(input int len);
      logic [DESC_TYPE_W-1:0] t;
      logic [PHYS_W-1:0]      s;
      logic [PHYS_W-1:0]      next_s;
      logic [PAGES_W-1:0]     p;
      int                     r;
      t = pick_type();
      s = pick_addr();
      for (int i = 0; i < len; i++) begin
         p = pick_pages();
         offer_desc(t, s, p, i == len - 1);
         next_s = s + ({12'b0, p} << PAGE_SHIFT);
         r = $urandom_range(99);
         if (r < 55) begin
            s = next_s;
         end else if (r < 80) begin
            t = pick_type();
            s = next_s;
         end else if (r < 90) begin
            s = next_s + PHYS_W'($urandom_range(1, 16) * 4096);
         end else begin
            t = pick_type();
            s = pick_addr();
         end
      end
   endtask

   // Let the block drain, then write the slot register while it is idle.
   task automatic write_first_slot(input logic [COUNT_W-1:0] v);
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      tracker.set_first_slot(v);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One phase: a register setting followed by maps and stray descriptors.
   task automatic run_phase(input logic [COUNT_W-1:0] slot0, input int quota);
      int phase_start;
      write_first_slot(slot0);
      phase_start = descs_sent;
      while (descs_sent - phase_start < quota) begin
         if ($urandom_range(99) < 85) begin
            send_map(($urandom_range(99) < 10) ? $urandom_range(40, 90)
                                                : $urandom_range(1, 25));
         end else begin
            offer_desc(($urandom_range(1) != 0) ? $urandom() : pick_type(), pick_addr(),
                       pick_pages(), $urandom_range(99) < 30);
         end
      end
      req_bus.valid <= 1'b0;
   endtask

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.desc_type    = '0;
      req_bus.phys_start   = '0;
      req_bus.page_count   = '0;
      req_bus.is_last_desc = 1'b0;
      rsp_bus.ready        = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed map: merges, every class, extreme fields, saturation, wrap.
      offer_desc(EFI_CONVENTIONAL, 52'h0, 40'd16, 0);
      offer_desc(MT_LOADER_CODE, 52'h10000, 40'd16, 0);
      offer_desc(MT_LOADER_DATA, 52'h20000, 40'd1, 0);
      offer_desc(EFI_RT_CODE, 52'h100000, 40'd2, 0);
      offer_desc(EFI_RT_DATA, 52'h102000, 40'd0, 0);
      offer_desc(EFI_ACPI_RECLAIM, 52'h102000, 40'd1, 0);
      offer_desc(EFI_ACPI_NVS, 52'h103000, 40'd1, 0);
      offer_desc(EFI_MMIO, 52'h200000, 40'd1, 0);
      offer_desc(EFI_MMIO_PORT, 52'h201000, 40'd1, 0);
      offer_desc(32'd0, 52'h202000, 40'd1, 0);
      offer_desc(32'd8, 52'h203000, 40'd1, 0);
      offer_desc(32'd13, 52'h204000, 40'd1, 0);
      offer_desc(32'hFFFF_FFFF, 52'h205000, 40'd1, 0);
      offer_desc(EFI_BS_CODE, 52'h0, 40'hFF_FFFF_FFFF, 0);
      offer_desc(EFI_BS_DATA, 52'h0, 40'hFF_FFFF_FFFF, 0);
      offer_desc(32'd14, 52'h0, 40'hFF_FFFF_FFFF, 0);
      offer_desc(EFI_CONVENTIONAL, 52'hF_FFFF_FFFF_FFFF, 40'd1, 0);
      offer_desc(EFI_CONVENTIONAL, 52'h0, 40'd1, 1);
      // A map of one descriptor, then one whose last descriptor merges.
      offer_desc(MT_LOADER_DATA, 52'h5000, 40'd3, 1);
      offer_desc(EFI_MMIO, 52'hA_BCDE_F012_3000, 40'd5, 0);
      offer_desc(EFI_MMIO, 52'hA_BCDE_F012_8000, 40'd1, 1);
      req_bus.valid <= 1'b0;

      // Random maps under several slot settings, the extremes among them.
      run_phase(9'd256, 60);
      run_phase(9'd255, 60);
      run_phase(9'd0, 180);
      run_phase(9'd250, 180);
      run_phase(9'd1, 180);
      run_phase(9'd200, 180);
      run_phase(COUNT_W'($urandom_range(0, 256)), 180);
      run_phase(9'd128, 180);

      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d descriptors; checked %0d regions and %0d final reports.",
               descs_sent, tracker.regions_checked, tracker.finals_checked);
      $display("Words with overflow: %0d; failures: %0d.", tracker.overflows_checked,
               tracker.errors);
      if (tracker.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
